// ----- rtl/ptmg_pkg.sv -----
// ----------------------------------------------------------------------------
// ptmg_pkg
// Shared constants, types and elaboration-time functions for the pixel tone
// map and gamma unit.
// ----------------------------------------------------------------------------
package ptmg_pkg;

	// Fixed-point and sizing constants.
	localparam int MAX_RESOLUTION = 4096;
	localparam int QUO_BITS       = 17;
	localparam int LOG_STEPS      = 16;
	localparam int ROOT_STEPS     = 20;

	// Stage counts of the divider and the power pipelines.
	localparam int DIV_LAT    = QUO_BITS;
	localparam int POW_LAT    = 1 + LOG_STEPS + 2 + ROOT_STEPS + 1;
	localparam int PIPE_DEPTH = 1 + DIV_LAT + POW_LAT + 1;

	localparam logic [16:0] ONE_Q16   = 17'h10000;
	localparam logic [15:0] GAMMA_ONE = 16'd4096;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_MARK  = 2'd0,
		REG_GAMMA = 2'd1,
		REG_VRES  = 2'd2
	} reg_idx_t;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic        mark;
		logic [15:0] gamma;
		logic [12:0] vres;
	} cfg_t;

	// Integer square root, used only at elaboration.
	function automatic logic [63:0] int_sqrt(input logic [63:0] a);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bit_v;
		rem   = a;
		res   = '0;
		bit_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bit_v) begin
				rem = rem - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// Factor 2^(-2^-k) in Q30, built by repeated square roots from 0.5.
	function automatic logic [63:0] root_at(input int k);
		logic [63:0] t;
		t = 64'd1 << 29;
		for (int i = 1; i <= k; i++) begin
			t = int_sqrt(t << 30);
		end
		return t;
	endfunction

endpackage

// ----- rtl/ptmg_regs.sv -----
// ----------------------------------------------------------------------------
// ptmg_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module ptmg_regs
	import ptmg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark  <= 1'b0;
			cfg_q.gamma <= GAMMA_ONE;
			cfg_q.vres  <= 13'd400;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_MARK:  cfg_q.mark  <= pwdata[0];
				REG_GAMMA: cfg_q.gamma <= pwdata[15:0];
				REG_VRES:  cfg_q.vres  <= pwdata[12:0];
				default:   ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (paddr[3:2])
			REG_MARK:  prdata = {31'b0, cfg_q.mark};
			REG_GAMMA: prdata = {16'b0, cfg_q.gamma};
			REG_VRES:  prdata = {19'b0, cfg_q.vres};
			default:   prdata = '0;
		endcase
	end

endmodule

// ----- rtl/ptmg_div.sv -----
// ----------------------------------------------------------------------------
// ptmg_div
// Pipelined restoring divider: num * 65536 / den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module ptmg_div
	import ptmg_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [23:0] num,
	input  logic [23:0] den,
	input  logic        byp,
	output logic [16:0] quo
);

	logic [24:0] rem_s  [QUO_BITS];
	logic [23:0] den_s  [QUO_BITS];
	logic [16:0] q_s    [QUO_BITS];
	logic [16:0] pass_s [QUO_BITS];
	logic        byp_s  [QUO_BITS];

	// One compare and subtract per stage.
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
		logic [24:0] rem_in;
		logic [23:0] den_in;
		logic [16:0] q_in;
		logic [16:0] pass_in;
		logic        byp_in;
		logic        ge;
		logic [24:0] sel;

		if (i == 0) begin : g_first
			assign rem_in  = {1'b0, num};
			assign den_in  = den;
			assign q_in    = '0;
			assign pass_in = num[16:0];
			assign byp_in  = byp;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign q_in    = q_s[i-1];
			assign pass_in = pass_s[i-1];
			assign byp_in  = byp_s[i-1];
		end

		assign ge  = rem_in >= {1'b0, den_in};
		assign sel = ge ? (rem_in - {1'b0, den_in}) : rem_in;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= {sel[23:0], 1'b0};
				den_s[i]  <= den_in;
				q_s[i]    <= {q_in[15:0], ge};
				pass_s[i] <= pass_in;
				byp_s[i]  <= byp_in;
			end
		end
	end

	// Channels that need no scaling pass through unchanged.
	assign quo = byp_s[QUO_BITS-1] ? pass_s[QUO_BITS-1] : q_s[QUO_BITS-1];

endmodule

// ----- rtl/ptmg_pow.sv -----
// ----------------------------------------------------------------------------
// ptmg_pow
// Pipelined power v^g for a UQ1.16 channel: log2 by repeated squaring,
// one exponent multiply, then exp2 by a chain of root-factor multiplies.
// ----------------------------------------------------------------------------
module ptmg_pow
	import ptmg_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] v,
	input  logic [15:0] gamma,
	output logic [16:0] res
);

	logic [30:0] x_a;
	logic [3:0]  n_a;
	logic [16:0] v_a;
	logic [30:0] x_c;
	logic [3:0]  n_c;

	logic [30:0] x_l  [LOG_STEPS];
	logic [15:0] lf_l [LOG_STEPS];
	logic [3:0]  n_l  [LOG_STEPS];
	logic [16:0] v_l  [LOG_STEPS];

	logic [20:0] ell_e;
	logic [16:0] v_e;
	logic [36:0] p_m;
	logic [16:0] v_m;

	logic [30:0] r_x [ROOT_STEPS];
	logic [36:0] p_x [ROOT_STEPS];
	logic [16:0] v_x [ROOT_STEPS];

	logic [16:0] res_f;
	logic [8:0]  ip;
	logic [5:0]  sh;
	logic [30:0] shifted;
	logic [16:0] res_c;
	logic [16:0] v_last;

	// Normalize: find the leading one and left-align the mantissa in Q30.
	always_comb begin
		n_c = '0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				n_c = 4'(i);
			end
		end
		x_c = {15'b0, v[15:0]} << (5'd30 - {1'b0, n_c});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_a <= x_c;
			n_a <= n_c;
			v_a <= v;
		end
	end

	// Log2 fraction, one bit per squaring stage.
	for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log
		logic [30:0] x_in;
		logic [15:0] lf_in;
		logic [3:0]  n_in;
		logic [16:0] v_in;
		logic [61:0] sq;
		logic [31:0] t;

		if (j == 0) begin : g_first
			assign x_in  = x_a;
			assign lf_in = '0;
			assign n_in  = n_a;
			assign v_in  = v_a;
		end else begin : g_next
			assign x_in  = x_l[j-1];
			assign lf_in = lf_l[j-1];
			assign n_in  = n_l[j-1];
			assign v_in  = v_l[j-1];
		end

		assign sq = {31'b0, x_in} * {31'b0, x_in};
		assign t  = sq[61:30];

		always_ff @(posedge clk) begin
			if (en) begin
				x_l[j]  <= t[31] ? t[31:1] : t[30:0];
				lf_l[j] <= {lf_in[14:0], t[31]};
				n_l[j]  <= n_in;
				v_l[j]  <= v_in;
			end
		end
	end

	// Negative log2 of v as UQ5.16, then the scaled exponent.
	always_ff @(posedge clk) begin
		if (en) begin
			ell_e <= {5'd16 - {1'b0, n_l[LOG_STEPS-1]}, 16'b0}
				- {5'b0, lf_l[LOG_STEPS-1]};
			v_e   <= v_l[LOG_STEPS-1];
			p_m   <= {16'b0, ell_e} * {21'b0, gamma};
			v_m   <= v_e;
		end
	end

	// Exp2 of the fraction: multiply in each selected root factor.
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_exp
		localparam logic [29:0] ROOT_K = 30'(root_at(k + 1));
		logic [30:0] r_in;
		logic [36:0] p_in;
		logic [16:0] v_in;
		logic [60:0] prod;

		if (k == 0) begin : g_first
			assign r_in = 31'h4000_0000;
			assign p_in = p_m;
			assign v_in = v_m;
		end else begin : g_next
			assign r_in = r_x[k-1];
			assign p_in = p_x[k-1];
			assign v_in = v_x[k-1];
		end

		assign prod = {30'b0, r_in} * {31'b0, ROOT_K};

		always_ff @(posedge clk) begin
			if (en) begin
				r_x[k] <= p_in[27 - k] ? prod[60:30] : r_in;
				p_x[k] <= p_in;
				v_x[k] <= v_in;
			end
		end
	end

	// Integer part of the exponent shifts the result; special values override.
	always_comb begin
		ip      = p_x[ROOT_STEPS-1][36:28];
		v_last  = v_x[ROOT_STEPS-1];
		sh      = 6'(ip) + 6'd14;
		shifted = r_x[ROOT_STEPS-1] >> sh;
		if (gamma == GAMMA_ONE) begin
			res_c = v_last;
		end else if (v_last == '0) begin
			res_c = (gamma == '0) ? ONE_Q16 : '0;
		end else if (v_last[16]) begin
			res_c = ONE_Q16;
		end else if (ip >= 9'd40) begin
			res_c = '0;
		end else begin
			res_c = shifted[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_f <= res_c;
		end
	end

	assign res = res_f;

endmodule

// ----- rtl/pixel_tone_map_gamma_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_tone_map_gamma_unit
// Maps one UQ8.16 RGB pixel per clock to an 8-bit display pixel. Out-of-range
// pixels are either painted red or scaled by their largest channel, then
// each channel is raised to the inverse-gamma power (UQ4.12) and truncated
// to 255*v; the row is flipped to a screen y. The unit takes one pixel
// transfer per cycle, but a stall on the output freezes the whole pipeline.
// It holds one stage for gamut handling, 17 divider stages (one quotient
// bit each), 40 power stages (a normalization stage, 16 squaring steps for
// log2, two for the exponent, 20 root-factor multiplies for exp2, one final
// shift) and the output register. The user must write configuration over the
// APB-style port while no pixel is in flight; the unit does not check this.
// ----------------------------------------------------------------------------
module pixel_tone_map_gamma_unit
	import ptmg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] pixel_row,
	input  logic [11:0] pixel_column,
	input  logic [23:0] red_in,
	input  logic [23:0] green_in,
	input  logic [23:0] blue_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] screen_x,
	output logic [11:0] screen_y,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out
);

	localparam int SIDE_LEN = DIV_LAT + POW_LAT;

	cfg_t        cfg;
	logic        en;
	logic        vld_s [PIPE_DEPTH];

	logic [23:0] ch_c [3];
	logic [23:0] top_c;
	logic        byp_c;
	logic [12:0] vres_c;
	logic [13:0] y_c;
	logic [11:0] y_sat;

	logic [23:0] ch_s1 [3];
	logic [23:0] top_s1;
	logic        byp_s1;
	logic [11:0] col_s1;
	logic [11:0] y_s1;

	logic [23:0] side_s [SIDE_LEN];
	logic [16:0] quo [3];
	logic [16:0] pw [3];
	logic [24:0] scl [3];

	ptmg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The pipeline advances unless a finished result is held by the sink.
	assign en       = !(vld_s[PIPE_DEPTH-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_s[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Gamut handling and screen y.
	always_comb begin
		ch_c[0] = red_in;
		ch_c[1] = green_in;
		ch_c[2] = blue_in;
		top_c   = red_in;
		if (green_in > top_c) begin
			top_c = green_in;
		end
		if (blue_in > top_c) begin
			top_c = blue_in;
		end
		byp_c = 1'b1;
		if (cfg.mark) begin
			if (top_c > 24'(ONE_Q16)) begin
				ch_c[0] = 24'(ONE_Q16);
				ch_c[1] = '0;
				ch_c[2] = '0;
			end
		end else if (top_c > 24'(ONE_Q16)) begin
			byp_c = 1'b0;
		end
		vres_c = (cfg.vres > 13'(MAX_RESOLUTION)) ? 13'(MAX_RESOLUTION) : cfg.vres;
		y_c    = {1'b0, vres_c} - {2'b0, pixel_row} - 14'd1;
		if (y_c[13]) begin
			y_sat = '0;
		end else if (y_c > 14'd4095) begin
			y_sat = 12'd4095;
		end else begin
			y_sat = y_c[11:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1  <= ch_c;
			top_s1 <= top_c;
			byp_s1 <= byp_c;
			col_s1 <= pixel_column;
			y_s1   <= y_sat;
		end
	end

	// Column and screen y travel alongside the channel pipelines.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= {col_s1, y_s1};
			for (int i = 1; i < SIDE_LEN; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Per-channel scaling and power.
	for (genvar c = 0; c < 3; c++) begin : g_ch
		ptmg_div u_div (
			.clk (clk),
			.en  (en),
			.num (ch_s1[c]),
			.den (top_s1),
			.byp (byp_s1),
			.quo (quo[c])
		);

		ptmg_pow u_pow (
			.clk   (clk),
			.en    (en),
			.v     (quo[c]),
			.gamma (cfg.gamma),
			.res   (pw[c])
		);

		assign scl[c] = {8'b0, pw[c]} * 25'd255;
	end

	// Output register: truncated 255*v and screen coordinates.
	always_ff @(posedge clk) begin
		if (en) begin
			screen_x  <= side_s[SIDE_LEN-1][23:12];
			screen_y  <= side_s[SIDE_LEN-1][11:0];
			red_out   <= scl[0][23:16];
			green_out <= scl[1][23:16];
			blue_out  <= scl[2][23:16];
		end
	end

endmodule
